@@ hdl/bba_pkg.sv @@
package bba_pkg;

    // Largest block index reach of the 12-bit index fields.
    localparam int INDEX_SPAN = 4096;

    // Free counter saturates here.
    localparam logic [12:0] COUNT_MAX = 13'h1FFF;

    // Map layout: eight blocks per byte, lowest block in the top bit.
    localparam logic [2:0] BIT_MASK = 3'h7;
    localparam logic [7:0] TOP_BIT  = 8'h80;

    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_ALLOC  = 2'd1;
    localparam logic [1:0] KIND_FREE   = 2'd2;
    localparam logic [1:0] KIND_TEST   = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  count;
        logic [11:0] block_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] granted_block;
        logic        granted_valid;
        logic        bit_value;
        logic        last;
        logic [12:0] free_count;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_FORMAT,
        ST_FMT_REPLY,
        ST_SCAN,
        ST_FETCH,
        ST_GRANT
    } state_t;

    typedef enum logic [2:0] {
        RP_OK,
        RP_SHORT,
        RP_RANGE,
        RP_BIT,
        RP_GRANT
    } reply_t;

    typedef enum logic [1:0] {
        ROW_HOLD,
        ROW_ZERO,
        ROW_INC
    } row_op_t;

    typedef enum logic [1:0] {
        WR_ZERO,
        WR_FREE,
        WR_WORD
    } wr_sel_t;

    typedef enum logic [1:0] {
        FB_HOLD,
        FB_LOAD,
        FB_INC,
        FB_SUB
    } fb_op_t;

    typedef struct packed {
        logic    accept;
        row_op_t row_op;
        logic    acc_ld;
        logic    word_ld;
        logic    grant;
        logic    wr_en;
        wr_sel_t wr_sel;
        fb_op_t  fb_op;
        logic    emit;
        reply_t  reply;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       bad_index;
        logic       oversize;
        logic       zero_req;
        logic       short_req;
        logic       enough;
        logic       last_row;
        logic       last_clear_row;
        logic       has_free;
        logic       final_grant;
        logic       out_free;
    } stat_t;

endpackage

@@ hdl/bba_ctrl.sv @@
module bba_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bba_pkg::stat_t stat,
    output bba_pkg::cmd_t  cmd
);
    import bba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT, ST_FORMAT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_ZERO;
                cmd.row_op = ROW_INC;
                if (stat.last_clear_row)
                begin
                    cmd.row_op = ROW_HOLD;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_FMT_REPLY;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.kind)
                    KIND_FORMAT:
                    begin
                        state_next = ST_FORMAT;
                    end
                    KIND_ALLOC:
                    begin
                        if (!stat.oversize && !stat.zero_req && !stat.short_req)
                        begin
                            state_next = ST_SCAN;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit = 1'b1;
                            priority if (stat.oversize)
                                cmd.reply = RP_RANGE;
                            else if (stat.zero_req)
                                cmd.reply = RP_OK;
                            else
                                cmd.reply = RP_SHORT;
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_FREE, KIND_TEST:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = ST_IDLE;
                            if (stat.bad_index)
                            begin
                                cmd.reply = RP_RANGE;
                            end
                            else if (stat.kind == KIND_FREE)
                            begin
                                cmd.reply  = RP_OK;
                                cmd.wr_en  = 1'b1;
                                cmd.wr_sel = WR_FREE;
                                cmd.fb_op  = FB_INC;
                            end
                            else
                            begin
                                cmd.reply = RP_BIT;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FMT_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.reply  = RP_OK;
                    cmd.fb_op  = FB_LOAD;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (stat.enough)
                begin
                    cmd.row_op = ROW_ZERO;
                    state_next = ST_FETCH;
                end
                else if (stat.last_row)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.reply  = RP_SHORT;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.acc_ld = 1'b1;
                    cmd.row_op = ROW_INC;
                end
            end
            ST_FETCH:
            begin
                cmd.word_ld = 1'b1;
                state_next  = ST_GRANT;
            end
            ST_GRANT:
            begin
                if (!stat.has_free)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_WORD;
                    cmd.row_op = ROW_INC;
                    state_next = ST_FETCH;
                end
                else if (stat.out_free)
                begin
                    cmd.emit  = 1'b1;
                    cmd.reply = RP_GRANT;
                    cmd.grant = 1'b1;
                    if (stat.final_grant)
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = WR_WORD;
                        cmd.fb_op  = FB_SUB;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/bba_datapath.sv @@
module bba_datapath #(
    parameter int ROWS    = 512,
    parameter int ROW_W   = 9,
    parameter int MAX_RUN = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  bba_pkg::cmd_t  cmd,
    output bba_pkg::stat_t stat,
    input  bba_pkg::req_t  req,
    input  logic [12:0]    limit,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bba_pkg::rsp_t  rsp
);
    import bba_pkg::*;

    logic [7:0]       map_mem [ROWS];
    logic [7:0]       rd_data_reg;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    req_t             item_reg;
    logic [6:0]       acc_reg;
    logic [6:0]       gcnt_reg;
    logic [7:0]       word_reg;
    logic [12:0]      free_reg;
    logic [12:0]      free_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic [12:0] row_base;
    logic [7:0]  elig;
    logic [7:0]  row_free;
    logic [3:0]  row_cnt;
    logic [7:0]  acc_sum;
    logic [7:0]  avail;
    logic [7:0]  gmask;
    logic [2:0]  gpos;
    logic [2:0]  bsel;
    logic [7:0]  bmask;
    logic        bit_val;
    logic [7:0]  wr_data;
    logic        out_free;
    rsp_t        rsp_new;

    assign row_base = 13'({row_reg, 3'b000});

    // Blocks of the current byte that lie below the limit.
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            elig[7 - k] = (row_base + 13'(k)) < limit;
        end
    end

    assign row_free = ~rd_data_reg & elig;

    always_comb
    begin
        row_cnt = '0;
        for (int k = 0; k < 8; k++)
        begin
            row_cnt = row_cnt + 4'(row_free[k]);
        end
    end

    assign acc_sum = {1'b0, acc_reg} + 8'(row_cnt);

    // First free block of the held byte; the top bit is the lowest block.
    assign avail = ~word_reg & elig;

    always_comb
    begin
        gmask = '0;
        gpos  = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (avail[k])
            begin
                gmask = 8'(1) << k;
                gpos  = 3'(7 - k);
            end
        end
    end

    assign bsel    = item_reg.block_index[2:0] & BIT_MASK;
    assign bmask   = TOP_BIT >> bsel;
    assign bit_val = |(rd_data_reg & bmask);

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_ZERO: wr_data = '0;
            WR_FREE: wr_data = rd_data_reg & ~bmask;
            WR_WORD: wr_data = word_reg | gmask;
            default: wr_data = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.accept)
        begin
            if (req.kind == KIND_FREE || req.kind == KIND_TEST)
                row_next = ROW_W'(req.block_index >> 3);
            else
                row_next = '0;
        end
        else
        begin
            unique case (cmd.row_op)
                ROW_HOLD: row_next = row_reg;
                ROW_ZERO: row_next = '0;
                ROW_INC:  row_next = row_reg + ROW_W'(1);
                default:  row_next = row_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cmd.fb_op)
            FB_HOLD: free_next = free_reg;
            FB_LOAD: free_next = limit;
            FB_INC:  free_next = (bit_val && free_reg != COUNT_MAX) ?
                                 free_reg + 13'd1 : free_reg;
            FB_SUB:  free_next = free_reg - 13'(item_reg.count);
            default: free_next = free_reg;
        endcase
    end

    // Map memory: one byte per row, registered read of the next row address.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            map_mem[row_reg] <= wr_data;
        end
        rd_data_reg <= map_mem[row_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            free_reg <= '0;
            acc_reg  <= '0;
            gcnt_reg <= '0;
        end
        else
        begin
            row_reg  <= row_next;
            free_reg <= free_next;
            if (cmd.accept)
            begin
                acc_reg  <= '0;
                gcnt_reg <= '0;
            end
            else
            begin
                if (cmd.acc_ld)
                    acc_reg <= acc_sum[6:0];
                if (cmd.grant)
                    gcnt_reg <= gcnt_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= req;
        end
        if (cmd.word_ld)
        begin
            word_reg <= rd_data_reg;
        end
        else if (cmd.grant)
        begin
            word_reg <= word_reg | gmask;
        end
    end

    always_comb
    begin
        rsp_new               = '0;
        rsp_new.status        = STATUS_OK;
        rsp_new.last          = 1'b1;
        rsp_new.free_count    = free_next;
        unique case (cmd.reply)
            RP_OK:    rsp_new.status = STATUS_OK;
            RP_SHORT: rsp_new.status = STATUS_SHORT;
            RP_RANGE: rsp_new.status = STATUS_RANGE;
            RP_BIT:   rsp_new.bit_value = bit_val;
            RP_GRANT:
            begin
                rsp_new.granted_valid = 1'b1;
                rsp_new.granted_block = 12'({row_reg, gpos});
                rsp_new.last          = stat.final_grant;
                rsp_new.free_count    = free_reg - 13'(item_reg.count);
            end
            default:  rsp_new.status = STATUS_OK;
        endcase
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg <= rsp_new;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign stat.kind           = item_reg.kind;
    assign stat.bad_index      = {1'b0, item_reg.block_index} >= limit;
    assign stat.oversize       = item_reg.count > 7'(MAX_RUN);
    assign stat.zero_req       = (item_reg.count == 7'd0);
    assign stat.short_req      = 13'(item_reg.count) > free_reg;
    assign stat.enough         = acc_sum >= {1'b0, item_reg.count};
    assign stat.last_row       = (row_base + 13'd8) >= limit;
    assign stat.last_clear_row = (row_reg == ROW_W'(ROWS - 1));
    assign stat.has_free       = |avail;
    assign stat.final_grant    = ((gcnt_reg + 7'd1) == item_reg.count);
    assign stat.out_free       = out_free;

endmodule

@@ hdl/bitmap_block_allocator.sv @@
// Bitmap block allocator. The block keeps one usage bit per data block (1 means
// used) in an on-chip byte-wide memory, eight blocks per byte, and a 13-bit free
// block counter. An item on the request channel is a format, an allocate of up
// to MAX_RUN blocks, a free of one block, or a test of one bit; each item gives
// one result item, except a successful allocate of N blocks, which gives N
// grant items with last on the final one. Allocation is first fit from block 0
// and all or nothing: a first pass reads the map one byte per cycle, counting
// free blocks below the limit until the request is covered, and a second pass
// rereads the map from the start, loading each byte, granting its free blocks
// one at a time and writing the byte back. A stalled result holds the block
// for as long as the stall lasts. Format and the start-up after reset clear
// the whole map, one byte per cycle, and no request item is taken meanwhile.
// The limit is block_count, clamped to NUM_BLOCKS and to 4096. block_count is
// written through the cfg channel, which is always ready, and should only be
// written while the block is idle.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = 4096,
    parameter int MAX_RUN    = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bba_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bba_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [12:0]   cfg_data
);
    import bba_pkg::*;

    // Blocks beyond the 12-bit index reach are never addressed, so the map
    // stops there.
    localparam int MAP_BLOCKS = (NUM_BLOCKS < INDEX_SPAN) ? NUM_BLOCKS : INDEX_SPAN;
    localparam int ROWS       = (MAP_BLOCKS + 7) / 8;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [12:0] block_count_reg;
    logic [12:0] limit;
    cmd_t        cmd;
    stat_t       stat;

    // The configuration register resets to the full 4096-block span.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= 13'd4096;
        end
        else if (cfg_valid && cfg_ready)
        begin
            block_count_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // Effective limit for indices and scans.
    assign limit = (block_count_reg > 13'(MAP_BLOCKS)) ? 13'(MAP_BLOCKS) : block_count_reg;

    // The controller sequences the clear, scan and grant passes; the datapath
    // holds the map, the counters and the result register.
    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bba_datapath #(
        .ROWS    (ROWS),
        .ROW_W   (ROW_W),
        .MAX_RUN (MAX_RUN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .limit     (limit),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // A granted block is always a successful one and lies below the limit.
    a_grant_in_range : assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.granted_valid) |->
            (rsp.status == STATUS_OK && {1'b0, rsp.granted_block} < limit)
    ) else $error("granted block is out of range or not ok");

    // Once an item is taken, the block is busy in the next cycle.
    a_busy_after_accept : assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall
    ) else $error("request channel not stalled after accept");

    // An error result is a single, final result without a grant.
    a_error_single : assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != STATUS_OK) |-> (rsp.last && !rsp.granted_valid)
    ) else $error("error result carries a grant or is not final");

endmodule
